// ----- hdl/trar_pkg.sv -----
// ---------------------------------------------------------------------------
// trar_pkg
// Shared types, constants and register codes of the temperature report and
// alarm block.
// ---------------------------------------------------------------------------
package trar_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int CMP_W       = (VALUE_WIDTH + 2 > 18) ? VALUE_WIDTH + 2 : 18;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam cmp_t VALUE_MAX = cmp_t'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam cmp_t VALUE_MIN = -VALUE_MAX - cmp_t'(1);

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_HIGH_ND = 2'd1;
  localparam logic [1:0] KIND_LOW_ND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENABLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENABLE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_PERIOD    = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic               report_now;
    logic signed [15:0] corrected_value;
    logic               high_alarm;
    logic               low_alarm;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] sensor_offset;
    logic [14:0]        change_threshold;
    logic signed [15:0] high_level;
    logic signed [15:0] low_level;
    logic               high_enable;
    logic               low_enable;
    logic [14:0]        hysteresis;
    logic [15:0]        resend_period;
  } cfg_t;

  typedef struct packed {
    logic high_latched;
    logic low_latched;
  } alarm_status_t;

endpackage

// ----- hdl/temperature_report_and_alarm_top.sv -----
// ---------------------------------------------------------------------------
// temperature_report_and_alarm_top
// Deadband report and hysteresis alarm for a temperature sample stream.
// ---------------------------------------------------------------------------
// One result per input transaction, one transaction per cycle sustained while
// out_ready holds. A transaction is held in the input register, evaluated in
// a single pass against the report and alarm state, and lands in the output
// register. in_ready follows out_ready through the two register stages.
// Configuration writes are accepted every cycle and belong to idle periods.
// ---------------------------------------------------------------------------
module temperature_report_and_alarm_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  trar_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output trar_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [trar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trar_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                    s1_valid_r, s1_valid_nxt;
  trar_pkg::in_item_t      s1_item_r;
  logic                    out_valid_r, out_valid_nxt;
  trar_pkg::out_item_t     out_item_r;
  logic                    in_fire, s1_fire, out_adv, cfg_fire;
  trar_pkg::cfg_t          cfg;
  logic                    clear_latches;
  trar_pkg::out_item_t     core_result;
  trar_pkg::alarm_status_t status;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_adv   = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_fire   = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  trar_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (cfg_fire),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .cfg           (cfg),
    .clear_latches (clear_latches)
  );

  trar_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_en       (s1_fire),
    .item          (s1_item_r),
    .cfg           (cfg),
    .clear_latches (clear_latches),
    .result        (core_result),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_level_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_index == trar_pkg::REG_HIGH_LEVEL ||
                  cfg_index == trar_pkg::REG_LOW_LEVEL ||
                  cfg_index == trar_pkg::REG_HIGH_ENABLE ||
                  cfg_index == trar_pkg::REG_LOW_ENABLE))
    |=> (!status.high_latched && !status.low_latched))
    else $error("alarm latch survived a level register write");

  a_high_alarm_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && core_result.high_alarm && !cfg_fire) |=> status.high_latched)
    else $error("high alarm fired without setting its latch");

  a_non_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.kind != trar_pkg::KIND_SAMPLE) |=> (out_data == '0))
    else $error("non-sample transaction produced a nonzero result");

endmodule

// ----- hdl/trar_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// trar_cfg_regs
// Configuration register file; flags writes that rearm the alarm latches.
// ---------------------------------------------------------------------------
module trar_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [trar_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [trar_pkg::CFG_DATA_W-1:0]   wr_data,
  output trar_pkg::cfg_t                    cfg,
  output logic                              clear_latches
);

  trar_pkg::cfg_t cfg_r;
  trar_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        trar_pkg::REG_SENSOR_OFFSET:    cfg_nxt.sensor_offset    = $signed(wr_data[15:0]);
        trar_pkg::REG_CHANGE_THRESHOLD: cfg_nxt.change_threshold = wr_data[14:0];
        trar_pkg::REG_HIGH_LEVEL:       cfg_nxt.high_level       = $signed(wr_data[15:0]);
        trar_pkg::REG_LOW_LEVEL:        cfg_nxt.low_level        = $signed(wr_data[15:0]);
        trar_pkg::REG_HIGH_ENABLE:      cfg_nxt.high_enable      = wr_data[0];
        trar_pkg::REG_LOW_ENABLE:       cfg_nxt.low_enable       = wr_data[0];
        trar_pkg::REG_HYSTERESIS:       cfg_nxt.hysteresis       = wr_data[14:0];
        trar_pkg::REG_RESEND_PERIOD:    cfg_nxt.resend_period    = wr_data[15:0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  assign clear_latches = wr_en &&
                         (wr_index == trar_pkg::REG_HIGH_LEVEL ||
                          wr_index == trar_pkg::REG_LOW_LEVEL ||
                          wr_index == trar_pkg::REG_HIGH_ENABLE ||
                          wr_index == trar_pkg::REG_LOW_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_offset    <= 16'sd0;
      cfg_r.change_threshold <= 15'd13;
      cfg_r.high_level       <= 16'sd400;
      cfg_r.low_level        <= 16'sd320;
      cfg_r.high_enable      <= 1'b0;
      cfg_r.low_enable       <= 1'b0;
      cfg_r.hysteresis       <= 15'd16;
      cfg_r.resend_period    <= 16'd60;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/trar_core.sv -----
// ---------------------------------------------------------------------------
// trar_core
// Per-transaction datapath: offset and saturation, report decision with
// countdown, and the high and low alarm latches.
// ---------------------------------------------------------------------------
module trar_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_en,
  input  trar_pkg::in_item_t      item,
  input  trar_pkg::cfg_t          cfg,
  input  logic                    clear_latches,
  output trar_pkg::out_item_t     result,
  output trar_pkg::alarm_status_t status
);

  logic signed [trar_pkg::VALUE_WIDTH-1:0] last_reported_r, last_reported_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic        high_latched_r, high_latched_nxt;
  logic        low_latched_r, low_latched_nxt;

  trar_pkg::cmp_t sum;
  trar_pkg::cmp_t v;
  trar_pkg::cmp_t diff;
  trar_pkg::cmp_t diff_abs;
  trar_pkg::cmp_t high_c;
  trar_pkg::cmp_t low_c;
  trar_pkg::cmp_t hyst_c;
  trar_pkg::cmp_t thr_c;
  logic           report;

  always_comb begin
    sum = trar_pkg::cmp_t'($signed(item.sample_value)) +
          trar_pkg::cmp_t'($signed(cfg.sensor_offset));
    if (sum > trar_pkg::VALUE_MAX) begin
      v = trar_pkg::VALUE_MAX;
    end else if (sum < trar_pkg::VALUE_MIN) begin
      v = trar_pkg::VALUE_MIN;
    end else begin
      v = sum;
    end
    diff     = v - trar_pkg::cmp_t'(last_reported_r);
    diff_abs = (diff < 0) ? -diff : diff;
    thr_c    = trar_pkg::cmp_t'($signed({1'b0, cfg.change_threshold}));
    hyst_c   = trar_pkg::cmp_t'($signed({1'b0, cfg.hysteresis}));
    high_c   = trar_pkg::cmp_t'($signed(cfg.high_level));
    low_c    = trar_pkg::cmp_t'($signed(cfg.low_level));
    report   = (countdown_r == 16'd0) || (diff_abs > thr_c);
  end

  always_comb begin
    last_reported_nxt = last_reported_r;
    countdown_nxt     = countdown_r;
    high_latched_nxt  = high_latched_r;
    low_latched_nxt   = low_latched_r;
    result            = '0;
    if (item_en) begin
      case (item.kind)
        trar_pkg::KIND_SAMPLE: begin
          result.report_now      = report;
          result.corrected_value = v[15:0];
          if (report) begin
            last_reported_nxt = v[trar_pkg::VALUE_WIDTH-1:0];
            countdown_nxt     = cfg.resend_period;
          end else begin
            countdown_nxt = countdown_r - 16'd1;
          end
          if (v > high_c) begin
            if (cfg.high_enable && !high_latched_r) begin
              high_latched_nxt  = 1'b1;
              result.high_alarm = 1'b1;
            end
          end else if (v < high_c - hyst_c) begin
            high_latched_nxt = 1'b0;
          end
          if (v < low_c) begin
            if (cfg.low_enable && !low_latched_r) begin
              low_latched_nxt  = 1'b1;
              result.low_alarm = 1'b1;
            end
          end else if (v > low_c + hyst_c) begin
            low_latched_nxt = 1'b0;
          end
        end
        trar_pkg::KIND_HIGH_ND: high_latched_nxt = 1'b0;
        trar_pkg::KIND_LOW_ND:  low_latched_nxt  = 1'b0;
        default: ;
      endcase
    end
    if (clear_latches) begin
      high_latched_nxt = 1'b0;
      low_latched_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_reported_r <= '0;
      countdown_r     <= 16'd0;
      high_latched_r  <= 1'b0;
      low_latched_r   <= 1'b0;
    end else begin
      last_reported_r <= last_reported_nxt;
      countdown_r     <= countdown_nxt;
      high_latched_r  <= high_latched_nxt;
      low_latched_r   <= low_latched_nxt;
    end
  end

  assign status.high_latched = high_latched_r;
  assign status.low_latched  = low_latched_r;

endmodule
